// File: hdl/sat_pkg.sv
package sat_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SLOT_COUNT = 8;
  localparam int LINE_W = 8;
  localparam int DEFAULT_CHANNELS = 8;
  localparam int TDATA_W = SLOT_COUNT * SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;

  // Item kinds carried on the slave-side tuser.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic scan;
    logic clear;
    logic calibrate;
  } lane_ctrl_t;

endpackage

// File: hdl/sat_lane.sv
module sat_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  sat_pkg::lane_ctrl_t          ctrl,
  input  logic [sat_pkg::SAMPLE_W-1:0] sample,
  output logic                         hit
);
  import sat_pkg::*;

  logic [SAMPLE_W-1:0] chan_max;
  logic [SAMPLE_W-1:0] chan_min;
  logic [SAMPLE_W-1:0] threshold;
  logic [SAMPLE_W-1:0] chan_max_next;
  logic [SAMPLE_W-1:0] chan_min_next;
  logic [SAMPLE_W-1:0] threshold_next;
  logic [SAMPLE_W:0]   mid_sum;
  logic [SAMPLE_W-1:0] threshold_use;

  always_comb begin
    chan_max_next  = (sample > chan_max) ? sample : chan_max;
    chan_min_next  = (sample < chan_min) ? sample : chan_min;
    mid_sum        = {1'b0, chan_min_next} + {1'b0, chan_max_next};
    threshold_next = mid_sum[SAMPLE_W:1];
    // In calibrate mode the mask compares against the freshly updated midpoint.
    threshold_use  = ctrl.calibrate ? threshold_next : threshold;
    hit            = sample > threshold_use;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_max  <= '0;
      chan_min  <= SAMPLE_MAX;
      threshold <= '0;
    end else if (ctrl.clear) begin
      chan_max <= '0;
      chan_min <= SAMPLE_MAX;
    end else if (ctrl.scan && ctrl.calibrate) begin
      chan_max  <= chan_max_next;
      chan_min  <= chan_min_next;
      threshold <= threshold_next;
    end
  end

endmodule

// File: hdl/sat_merge.sv
module sat_merge #(
  parameter int CHANNELS = sat_pkg::DEFAULT_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [CHANNELS-1:0]        hits,
  output logic                       ready,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [sat_pkg::LINE_W-1:0] m_axis_tdata
);
  import sat_pkg::*;

  logic [LINE_W-1:0] line;
  logic              out_valid;
  logic [LINE_W-1:0] out_data;
  logic              skid_valid;
  logic [LINE_W-1:0] skid_data;
  logic              out_load;
  logic              skid_load;

  always_comb begin
    line = '0;
    line[CHANNELS-1:0] = hits;
  end

  assign ready         = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // The skid entry catches a result that arrives while the output is stalled.
  assign out_load  = (!out_valid || m_axis_tready) && (skid_valid || in_valid);
  assign skid_load = out_valid && !m_axis_tready && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_axis_tready) begin
        out_valid  <= skid_valid || in_valid;
        skid_valid <= 1'b0;
      end else if (in_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= skid_valid ? skid_data : line;
    end
    if (skid_load) begin
      skid_data <= line;
    end
  end

endmodule

// File: hdl/sensor_array_auto_threshold_unit.sv
// Line-sensor auto threshold. Each slave transfer carries one scan of eight
// 10-bit samples (channel 0 in the lowest bits) or, with tuser high, a clear
// command that resets the per-channel minimum and maximum without producing
// a result. In calibrate mode a scan folds each sample into its channel's
// extremes and moves the threshold to their midpoint; in run mode the stored
// thresholds are used as they are. Every scan yields one 8-bit mask, bit i
// set when sample i is strictly above threshold i; bits at and above CHANNELS
// read 0. One lane per channel updates and compares combinationally, so a scan
// is accepted every clock while s_axis_tready is high; its mask is registered
// in a two-entry output buffer that drops s_axis_tready only when both entries
// hold results the master side has not yet taken. The user must write
// calibrate_mode through cfg_wr_en/cfg_wr_data while the unit is idle, unchecked.
module sensor_array_auto_threshold_unit #(
  parameter int CHANNELS = sat_pkg::DEFAULT_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sat_pkg::TDATA_W-1:0] s_axis_tdata,  // sample_0 .. sample_7, 10 bits each
  input  logic                        s_axis_tuser,  // op
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [sat_pkg::LINE_W-1:0]  m_axis_tdata   // line_bits
);
  import sat_pkg::*;

  logic                calibrate_mode;
  logic                in_xfer;
  lane_ctrl_t          ctrl;
  logic [CHANNELS-1:0] hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrate_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      calibrate_mode <= cfg_wr_data;
    end
  end

  assign in_xfer        = s_axis_tvalid && s_axis_tready;
  assign ctrl.scan      = in_xfer && (s_axis_tuser == OP_SCAN);
  assign ctrl.clear     = in_xfer && (s_axis_tuser == OP_CLEAR);
  assign ctrl.calibrate = calibrate_mode;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    sat_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sample (s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]),
      .hit    (hits[i])
    );
  end

  sat_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (ctrl.scan),
    .hits          (hits),
    .ready         (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: hdl/sat_checker.sv
module sat_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [sat_pkg::TDATA_W-1:0] s_axis_tdata,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [sat_pkg::LINE_W-1:0]  m_axis_tdata
);
  import sat_pkg::*;

  // A stalled result keeps its value until the transfer completes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Backpressure on the input only happens while a result is waiting.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // A clear command never produces a result.
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CLEAR) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("clear command produced a result");

  // An all-zero scan can never exceed any threshold.
  a_zero_scan: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SCAN) &&
    (s_axis_tdata == '0) && !m_axis_tvalid
    |=> m_axis_tvalid && (m_axis_tdata == '0))
    else $error("zero scan gave nonzero mask");

endmodule

bind sensor_array_auto_threshold_unit sat_checker u_sat_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
